>>> rtl/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg: shared definitions of the scaled decimal formatter
// Widths, ASCII codes and the job descriptor that travel between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

  localparam int unsigned ValueW  = 64;
  localparam int unsigned ScaleW  = 4;
  localparam int unsigned CharW   = 8;
  // The magnitude never exceeds 2^63, which has 19 decimal digits.
  localparam int unsigned DigitsN = 19;
  localparam int unsigned BcdW    = 4 * DigitsN;
  localparam int unsigned PosW    = $clog2(DigitsN);
  localparam int unsigned CntW    = $clog2(ValueW);
  localparam int unsigned FracW   = 3;

  localparam logic [ScaleW-1:0] DefaultScaleRst = ScaleW'(3);

  localparam logic [CharW-1:0] ChMinus = 8'h2d;
  localparam logic [CharW-1:0] ChPoint = 8'h2e;
  localparam logic [CharW-1:0] ChZero  = 8'h30;

  localparam logic OpTrim = 1'b0;
  localparam logic OpAlt  = 1'b1;

  // Per-transaction formatting job, held by the top level while busy.
  typedef struct packed {
    logic             neg;
    logic [FracW-1:0] frac;  // fraction digits held by the scale, 0 = integer
    logic             trim;  // drop the last fraction digit when it is zero
  } sdf_job_t;

endpackage

`default_nettype wire

>>> rtl/sdf_if.sv
// ----------------------------------------------------------------------------
// sdf_if: channel interfaces of the scaled decimal formatter
// Valid/ready channels for input items, output characters and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdf_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [sdf_pkg::ValueW-1:0]  value;
  logic        [sdf_pkg::ScaleW-1:0]  scale;
  logic                               operation;

  modport source (output valid, value, scale, operation, input ready);
  modport sink   (input valid, value, scale, operation, output ready);
endinterface

interface sdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [sdf_pkg::CharW-1:0]   character;
  logic                        last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

interface sdf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sdf_pkg::ScaleW-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> rtl/scaled_decimal_formatter_unit.sv
// ----------------------------------------------------------------------------
// scaled_decimal_formatter_unit: signed scaled integer to ASCII decimal text
// Accepts a value, scale and mode, and streams the decimal text one
// character per output transaction, with last on the final character.
// ----------------------------------------------------------------------------
// One item is in flight at a time. After the input transaction the 64-bit
// magnitude is converted to BCD one bit per cycle, leading zeros of the
// integer part are skipped one digit per cycle, and then the 1 to 21
// characters leave one per cycle while the output is ready. Each of the 19
// digit positions is skipped as a leading zero or emitted, except a trimmed
// trailing zero. The BCD converter is bit-serial. Input ready rises again
// once the last character's output transaction has completed, so a new
// item is not taken before the last one is through. The default-scale
// register may be written at any time the block is idle; its write channel
// is always ready.
`default_nettype none

module scaled_decimal_formatter_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sdf_in_if.sink      in_i,
  sdf_out_if.source   out_o,
  sdf_cfg_if.sink     cfg_i
);

  logic                          busy_q, busy_d;
  logic [sdf_pkg::ScaleW-1:0]    dflt_scale_q;
  sdf_pkg::sdf_job_t             job_q, job_d;
  logic                          in_fire;
  logic                          last_fire;
  logic [sdf_pkg::ScaleW-1:0]    eff_scale;
  logic [sdf_pkg::ValueW-1:0]    mag;
  logic                          conv_done;
  logic [sdf_pkg::BcdW-1:0]      conv_bcd;

  assign in_fire   = in_i.valid && in_i.ready;
  assign last_fire = out_o.valid && out_o.ready && out_o.last;
  assign in_i.ready  = !busy_q;
  assign cfg_i.ready = 1'b1;

  // A scale field of zero falls back to the default-scale register.
  assign eff_scale = (in_i.scale == '0) ? dflt_scale_q : in_i.scale;

  // The magnitude is taken modulo 2^64, so the most negative value still
  // yields a well-defined digit string.
  assign mag = in_i.value[sdf_pkg::ValueW-1] ? (~in_i.value + 1'b1) : in_i.value;

  // Trimming mode keeps one or two fraction digits fixed and lets scales
  // three to five drop a trailing zero; the alternate mode only knows the
  // three-place form. Everything else prints as a plain integer.
  always_comb begin
    job_d = job_q;
    if (in_fire) begin
      job_d.neg  = in_i.value[sdf_pkg::ValueW-1];
      job_d.frac = '0;
      job_d.trim = 1'b0;
      if (in_i.operation == sdf_pkg::OpTrim) begin
        if ((eff_scale >= 4'd1) && (eff_scale <= 4'd5)) begin
          job_d.frac = sdf_pkg::FracW'(eff_scale);
        end
        job_d.trim = (eff_scale >= 4'd3) && (eff_scale <= 4'd5);
      end else if (eff_scale == 4'd3) begin
        job_d.frac = sdf_pkg::FracW'(eff_scale);
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end else if (last_fire) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      dflt_scale_q <= sdf_pkg::DefaultScaleRst;
    end else begin
      busy_q <= busy_d;
      if (cfg_i.valid && cfg_i.ready) begin
        dflt_scale_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  sdf_bcd_conv u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_fire),
    .bin_i   (mag),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  sdf_emitter u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_done),
    .bcd_i   (conv_bcd),
    .job_i   (job_q),
    .out_o   (out_o)
  );

  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> busy_q)
    else $error("output character while no item is in flight");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input ready while an item is in flight");

endmodule

`default_nettype wire

>>> rtl/sdf_bcd_conv.sv
// ----------------------------------------------------------------------------
// sdf_bcd_conv: bit-serial binary to BCD converter
// Shift-and-add-three conversion, one magnitude bit per clock cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_bcd_conv (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [sdf_pkg::ValueW-1:0]   bin_i,
  output logic                              done_o,
  output logic      [sdf_pkg::BcdW-1:0]     bcd_o
);

  logic [sdf_pkg::ValueW-1:0] bin_q, bin_d;
  logic [sdf_pkg::BcdW-1:0]   bcd_q, bcd_d, adj;
  logic [sdf_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  // Every digit of 5 or more gets 3 added before the shift.
  always_comb begin
    for (int i = 0; i < sdf_pkg::DigitsN; i++) begin
      adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[sdf_pkg::BcdW-2:0], bin_q[sdf_pkg::ValueW-1]};
      bin_d = {bin_q[sdf_pkg::ValueW-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == {sdf_pkg::CntW{1'b1}}) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("conversion done while still shifting");

endmodule

`default_nettype wire

>>> rtl/sdf_emitter.sv
// ----------------------------------------------------------------------------
// sdf_emitter: character sequencer of the scaled decimal formatter
// Walks the BCD digits one per cycle while the output takes its characters, and emits sign, digits and point.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_emitter (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [sdf_pkg::BcdW-1:0]    bcd_i,
  input  wire sdf_pkg::sdf_job_t           job_i,
  sdf_out_if.source                        out_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSign  = 3'd1;
  localparam logic [2:0] StSkip  = 3'd2;
  localparam logic [2:0] StDigit = 3'd3;
  localparam logic [2:0] StPoint = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [sdf_pkg::BcdW-1:0]    sr_q, sr_d;
  logic [sdf_pkg::PosW-1:0]    pos_q, pos_d;
  logic                        endp_q, endp_d;
  logic                        ov_q, ov_d;
  logic                        last_q, last_d;
  logic [sdf_pkg::CharW-1:0]   ch_q, ch_d;
  logic [3:0]                  top_dig;
  logic [sdf_pkg::PosW-1:0]    frac_pos;
  logic [sdf_pkg::PosW-1:0]    end_pos;
  logic                        can_load;

  assign top_dig  = sr_q[sdf_pkg::BcdW-1 -: 4];
  assign frac_pos = sdf_pkg::PosW'(job_i.frac);
  assign end_pos  = sdf_pkg::PosW'(endp_q);
  assign can_load = !ov_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    sr_d    = sr_q;
    pos_d   = pos_q;
    endp_d  = endp_q;
    ov_d    = ov_q && !out_o.ready;
    last_d  = last_q;
    ch_d    = ch_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          sr_d    = bcd_i;
          pos_d   = sdf_pkg::PosW'(sdf_pkg::DigitsN - 1);
          endp_d  = job_i.trim && (bcd_i[3:0] == 4'd0);
          state_d = job_i.neg ? StSign : StSkip;
        end
      end
      StSign: begin
        if (can_load) begin
          ov_d    = 1'b1;
          ch_d    = sdf_pkg::ChMinus;
          last_d  = 1'b0;
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Leading zeros above the units position of the integer part are dropped.
        if ((pos_q > frac_pos) && (top_dig == 4'd0)) begin
          sr_d  = {sr_q[sdf_pkg::BcdW-5:0], 4'd0};
          pos_d = pos_q - 1'b1;
        end else begin
          state_d = StDigit;
        end
      end
      StDigit: begin
        if (can_load) begin
          ov_d   = 1'b1;
          ch_d   = sdf_pkg::ChZero + sdf_pkg::CharW'(top_dig);
          last_d = (pos_q == end_pos);
          if (pos_q == end_pos) begin
            state_d = StIdle;
          end else begin
            sr_d  = {sr_q[sdf_pkg::BcdW-5:0], 4'd0};
            pos_d = pos_q - 1'b1;
            if ((job_i.frac != '0) && (pos_q == frac_pos)) begin
              state_d = StPoint;
            end
          end
        end
      end
      StPoint: begin
        if (can_load) begin
          ov_d    = 1'b1;
          ch_d    = sdf_pkg::ChPoint;
          last_d  = 1'b0;
          state_d = StDigit;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q   <= sr_d;
    pos_q  <= pos_d;
    endp_q <= endp_d;
    last_q <= last_d;
    ch_q   <= ch_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.character = ch_q;
  assign out_o.last      = last_q;

  a_digit_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDigit) |-> (pos_q >= end_pos))
    else $error("digit position ran past the final digit");

  a_skip_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSkip) |-> (pos_q >= frac_pos))
    else $error("leading-zero skip went below the units digit");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the scaled decimal formatter
// Drives scaled integers with random idling on both channels. A built-in
// predictor turns each accepted item into the expected ASCII text, and every
// character transaction is compared against that text in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  // One input item as the bench keeps it before driving.
  typedef struct {
    logic signed [sdf_pkg::ValueW-1:0] value;
    logic        [sdf_pkg::ScaleW-1:0] scale;
    logic                              operation;
  } format_item_t;

  // One expected character of the formatted text.
  typedef struct {
    logic [sdf_pkg::CharW-1:0] character;
    logic                      last;
  } text_char_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sdf_in_if  in_if ();
  sdf_out_if out_if ();
  sdf_cfg_if cfg_if ();

  scaled_decimal_formatter_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #6 clk_i = ~clk_i;

  format_item_t              item_queue[$];     // items waiting for the driver
  text_char_t                expected_text[$];  // characters predicted, not yet seen
  logic [sdf_pkg::CharW-1:0] digit_scratch[$];  // text of the item being predicted
  logic [sdf_pkg::ScaleW-1:0] model_default_scale;

  bit in_fire;       // input transaction completed at the last rising edge
  bit calm;          // when set, neither side idles
  int mismatch_count;
  int items_accepted;
  int chars_checked;
  int settings_used;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Appends the decimal digits of n, padded with leading zeros to min_digits.
  function automatic void append_digits(logic [sdf_pkg::ValueW-1:0] n, int min_digits);
    logic [sdf_pkg::CharW-1:0] digits[20];
    int len;
    len = 0;
    do begin
      digits[len] = sdf_pkg::ChZero + sdf_pkg::CharW'(n % 10);
      n = n / 10;
      len++;
    end while (n != 0 && len < 20);
    while (len < min_digits && len < 20) begin
      digits[len] = sdf_pkg::ChZero;
      len++;
    end
    while (len > 0) begin
      len--;
      digit_scratch = {digit_scratch, digits[len]};
    end
  endfunction

  // Works out the full text of one item and queues it as expected characters.
  function automatic void predict_text(format_item_t it);
    logic                       neg;
    logic [sdf_pkg::ValueW-1:0] mag;
    logic [sdf_pkg::ValueW-1:0] divisor;
    logic [sdf_pkg::ValueW-1:0] int_part;
    logic [sdf_pkg::ValueW-1:0] frac_part;
    logic [sdf_pkg::ScaleW-1:0] eff_scale;
    int                         frac_digits;
    int                         shown_digits;
    text_char_t                 tc;
    neg = it.value[sdf_pkg::ValueW-1];
    // The magnitude wraps modulo 2^64, so the most negative value stays 2^63.
    mag = neg ? (sdf_pkg::ValueW'(0) - sdf_pkg::ValueW'(it.value))
              : sdf_pkg::ValueW'(it.value);
    eff_scale = (it.scale == '0) ? model_default_scale : it.scale;
    frac_digits = 0;
    shown_digits = 0;
    if (it.operation == sdf_pkg::OpTrim) begin
      if (eff_scale >= 3 && eff_scale <= 5) begin
        // Trimming drops the final fraction digit when it is a zero.
        frac_digits = eff_scale;
        shown_digits = (mag % 10 != 0) ? int'(eff_scale) : int'(eff_scale) - 1;
      end else if (eff_scale == 2 || eff_scale == 1) begin
        frac_digits = eff_scale;
        shown_digits = eff_scale;
      end
    end else if (eff_scale == 3) begin
      frac_digits = 3;
      shown_digits = 3;
    end

    digit_scratch.delete();
    if (neg) digit_scratch = {digit_scratch, sdf_pkg::ChMinus};
    if (frac_digits == 0) begin
      append_digits(mag, 1);
    end else begin
      divisor = 1;
      repeat (frac_digits) divisor = divisor * 10;
      int_part = mag / divisor;
      frac_part = mag % divisor;
      if (shown_digits < frac_digits) frac_part = frac_part / 10;
      append_digits(int_part, 1);
      digit_scratch = {digit_scratch, sdf_pkg::ChPoint};
      append_digits(frac_part, shown_digits);
    end
    foreach (digit_scratch[i]) begin
      tc.character = digit_scratch[i];
      tc.last = (i == digit_scratch.size() - 1);
      expected_text = {expected_text, tc};
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic format_item_t make_item(logic signed [sdf_pkg::ValueW-1:0] v,
                                             int s, logic op);
    format_item_t it;
    it.value = v;
    it.scale = sdf_pkg::ScaleW'(s);
    it.operation = op;
    return it;
  endfunction

  // Adds one item to the end of the driver's queue.
  function automatic void enqueue(format_item_t it);
    item_queue = {item_queue, it};
  endfunction

  // Random item. Many values are short enough that the fraction digits and
  // the trimming rule matter; others are full 64-bit words, 32-bit words, extremes and multiples of powers of ten.
  function automatic format_item_t random_item();
    format_item_t               it;
    int                         pick;
    int                         s_pick;
    logic [sdf_pkg::ValueW-1:0] p10;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: begin
        it.value = $urandom_range(0, 999999);
      end
      3: begin
        it.value = sdf_pkg::ValueW'($urandom_range(0, 99999)) * 10;
      end
      4, 5, 6: begin
        it.value = {$urandom(), $urandom()};
      end
      7: begin
        it.value = {32'h0, $urandom()};
      end
      8: begin
        case ($urandom_range(0, 3))
          0: it.value = 64'sh7fff_ffff_ffff_ffff;
          1: it.value = -64'sh7fff_ffff_ffff_ffff;
          2: it.value = 0;
          default: it.value = 1;
        endcase
      end
      default: begin
        p10 = 1;
        repeat ($urandom_range(0, 18)) p10 = p10 * 10;
        it.value = sdf_pkg::ValueW'($urandom_range(1, 9)) * p10;
      end
    endcase
    if (pick != 4 && pick != 5 && pick != 6 && $urandom_range(0, 1) == 1) begin
      it.value = -it.value;
    end
    // A zero scale selects the register, so it gets a generous share.
    s_pick = $urandom_range(0, 99);
    if (s_pick < 25) it.scale = '0;
    else if (s_pick < 75) it.scale = sdf_pkg::ScaleW'($urandom_range(1, 5));
    else it.scale = sdf_pkg::ScaleW'($urandom_range(6, 15));
    it.operation = ($urandom_range(0, 1) == 1) ? sdf_pkg::OpAlt : sdf_pkg::OpTrim;
    return it;
  endfunction

  // Writes the default-scale register. Called only while the block is idle.
  task automatic write_default_scale(logic [sdf_pkg::ScaleW-1:0] scale_value);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.data = scale_value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    model_default_scale = scale_value;
    settings_used++;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  // Blocks until every queued item is accepted and all its text has arrived.
  task automatic wait_drained();
    while (item_queue.size() != 0 || in_if.valid || expected_text.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: inputs change at the falling edge. A new item is presented only
  // once the previous one has been accepted, and the sender and the receiver
  // each hold off in about a quarter of the cycles unless calm is set.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= calm || ($urandom_range(0, 99) >= 25);
      if (!in_if.valid || in_fire) begin
        if (item_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          in_if.valid <= 1'b1;
          in_if.value <= item_queue[0].value;
          in_if.scale <= item_queue[0].scale;
          in_if.operation <= item_queue[0].operation;
          item_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. Each input transaction
  // queues its predicted text; each output transaction is checked against the
  // oldest predicted character.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    text_char_t want;
    format_item_t seen;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        seen.value = in_if.value;
        seen.scale = in_if.scale;
        seen.operation = in_if.operation;
        predict_text(seen);
        items_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character transaction: character 0x%02h last %0b",
                 out_if.character, out_if.last);
          mismatch_count++;
        end else begin
          want = expected_text.pop_front();
          chars_checked++;
          if (out_if.character !== want.character) begin
            $error("character mismatch: expected 0x%02h, actual 0x%02h",
                   want.character, out_if.character);
            mismatch_count++;
          end
          if (out_if.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_if.last);
            mismatch_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of the run: reset, directed items at the reset scale, then
  // random phases under several default-scale settings, the extremes among
  // them. The register is rewritten only after the block has drained.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int plan[8];
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.scale = '0;
    in_if.operation = sdf_pkg::OpTrim;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    calm = 1'b0;
    mismatch_count = 0;
    items_accepted = 0;
    chars_checked = 0;
    settings_used = 0;
    model_default_scale = sdf_pkg::DefaultScaleRst;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset default of three.
    write_default_scale(sdf_pkg::ScaleW'(3));
    enqueue(make_item(0, 3, sdf_pkg::OpTrim));         // zero value, trimmed
    enqueue(make_item(0, 0, sdf_pkg::OpAlt));          // zero via register
    enqueue(make_item(12345, 3, sdf_pkg::OpTrim));     // full three digits
    enqueue(make_item(12340, 3, sdf_pkg::OpTrim));     // trailing zero dropped
    enqueue(make_item(-12340, 4, sdf_pkg::OpTrim));
    enqueue(make_item(123450, 5, sdf_pkg::OpTrim));
    enqueue(make_item(123451, 5, sdf_pkg::OpTrim));
    enqueue(make_item(9, 5, sdf_pkg::OpTrim));         // padded fraction
    enqueue(make_item(10, 5, sdf_pkg::OpTrim));
    enqueue(make_item(7, 1, sdf_pkg::OpTrim));
    enqueue(make_item(-7, 2, sdf_pkg::OpTrim));
    enqueue(make_item(100, 1, sdf_pkg::OpTrim));
    enqueue(make_item(1000, 3, sdf_pkg::OpTrim));
    enqueue(make_item(-1, 0, sdf_pkg::OpTrim));        // register scale
    enqueue(make_item(5, 3, sdf_pkg::OpAlt));
    enqueue(make_item(5, 4, sdf_pkg::OpAlt));          // alternate, plain
    enqueue(make_item(64'sh7fff_ffff_ffff_ffff, 6, sdf_pkg::OpTrim));
    enqueue(make_item(-64'sh7fff_ffff_ffff_ffff, 15, sdf_pkg::OpAlt));
    enqueue(make_item(64'sh7fff_ffff_ffff_ffff, 3, sdf_pkg::OpAlt));
    enqueue(make_item(64'sh7fff_ffff_ffff_ffff, 2, sdf_pkg::OpTrim));
    enqueue(make_item(64'sh8000_0000_0000_0000, 3, sdf_pkg::OpTrim));
    enqueue(make_item(64'sh8000_0000_0000_0000, 9, sdf_pkg::OpAlt));

    // Random phases. Zero exercises the plain-integer default, fifteen the
    // top of the register range; one phase runs with no idling at all.
    plan = '{0, 15, 1, 2, 4, 5, 6, 0};
    plan[7] = $urandom_range(0, 15);
    foreach (plan[p]) begin
      wait_drained();
      write_default_scale(sdf_pkg::ScaleW'(plan[p]));
      calm = (p == 4);
      repeat (30) enqueue(random_item());
    end

    wait_drained();
    calm = 1'b0;
    // Let the block settle so that any stray character still shows up.
    repeat (120) @(posedge clk_i);

    $display("Checked %0d characters from %0d input items", chars_checked,
             items_accepted);
    $display("Default-scale register written %0d times, extremes 0 and 15 included",
             settings_used);
    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guards against a hang anywhere in the run.
  initial begin : watchdog
    #6000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
